@@ design/assert_macros.svh @@
// Assertion macros shared by the block's RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, clocked on clk, off while arst_n is low.
`define SWL_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("swl: implication check failed");

// Next-cycle implication, clocked on clk, off while arst_n is low.
`define SWL_ASSERT_NXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("swl: next-cycle check failed");

`endif

@@ design/swl_pkg.sv @@
// Types, constants and register indexes of the wildcard longest-match block.
`timescale 1ns / 1ps

package swl_pkg;

	localparam int MAX_PATTERN_DEF = 8;
	localparam int MAX_TEXT_DEF    = 65535;

	localparam int BYTE_W    = 8;
	localparam int CHARS_W   = 64;
	localparam int LEN_W     = 4;
	localparam int POS_W     = 16;
	localparam int BEST_W    = POS_W + 1;
	localparam int CFG_IDX_W = 8;

	localparam logic [CFG_IDX_W-1:0] REG_PREFIX_CHARS  = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_PREFIX_LENGTH = CFG_IDX_W'(1);
	localparam logic [CFG_IDX_W-1:0] REG_SUFFIX_CHARS  = CFG_IDX_W'(2);
	localparam logic [CFG_IDX_W-1:0] REG_SUFFIX_LENGTH = CFG_IDX_W'(3);

	localparam logic signed [BEST_W-1:0] BEST_NONE = '1;

	// Pattern settings, lengths already clamped to the window depth.
	typedef struct packed {
		logic [CHARS_W-1:0] prefix_chars;
		logic [LEN_W-1:0]   prefix_len;
		logic [CHARS_W-1:0] suffix_chars;
		logic [LEN_W-1:0]   suffix_len;
	} cfg_t;

	// What the window stage hands to the tracker for one item.
	typedef struct packed {
		logic             pre_hit;
		logic             suf_hit;
		logic [POS_W-1:0] end_pos;
		logic [POS_W-1:0] pre_start;
		logic [POS_W-1:0] suf_start;
		logic             last;
		logic             ovf;
	} stage_t;

endpackage

@@ design/swl_in_if.sv @@
// Text input channel: one byte and its end-of-text mark per item.
`timescale 1ns / 1ps

interface swl_in_if;
	import swl_pkg::*;

	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] text_byte;
	logic              end_of_text;

	modport source (output valid, output text_byte, output end_of_text, input ready);
	modport sink   (input valid, input text_byte, input end_of_text, output ready);
endinterface

@@ design/swl_out_if.sv @@
// Result channel: best length so far with end and overflow flags.
`timescale 1ns / 1ps

interface swl_out_if;
	import swl_pkg::*;

	logic                     valid;
	logic                     ready;
	logic signed [BEST_W-1:0] best_length;
	logic                     text_done;
	logic                     overflow;

	modport source (output valid, output best_length, output text_done, output overflow,
		input ready);
	modport sink   (input valid, input best_length, input text_done, input overflow,
		output ready);
endinterface

@@ design/swl_cfg_if.sv @@
// Configuration write channel: register index and write data.
`timescale 1ns / 1ps

interface swl_cfg_if;
	import swl_pkg::*;

	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] index;
	logic [CHARS_W-1:0]   data;

	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

@@ design/swl_cell.sv @@
// One window cell: holds a byte, passes it on, compares it with both patterns.
`timescale 1ns / 1ps

module swl_cell #(
	parameter int IDX = 0
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        en,
	input  logic                        clr,
	input  logic [swl_pkg::BYTE_W-1:0]  byte_in,
	input  swl_pkg::cfg_t               cfg,
	output logic [swl_pkg::BYTE_W-1:0]  byte_q,
	output logic                        pre_eq,
	output logic                        suf_eq
);
	import swl_pkg::*;

	localparam logic [LEN_W-1:0] AGE = LEN_W'(IDX);

	logic [LEN_W-1:0]  pre_sel;
	logic [LEN_W-1:0]  suf_sel;
	logic [BYTE_W-1:0] pre_byte;
	logic [BYTE_W-1:0] suf_byte;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_q <= '0;
		end else if (en) begin
			byte_q <= clr ? '0 : byte_in;
		end
	end

	// age a meets pattern byte (len - 1 - a); ages at or past len always agree
	always_comb begin
		pre_sel  = cfg.prefix_len - AGE - LEN_W'(1);
		suf_sel  = cfg.suffix_len - AGE - LEN_W'(1);
		pre_byte = cfg.prefix_chars[{pre_sel[2:0], 3'b000} +: BYTE_W];
		suf_byte = cfg.suffix_chars[{suf_sel[2:0], 3'b000} +: BYTE_W];
		pre_eq   = (AGE >= cfg.prefix_len) || (byte_q == pre_byte);
		suf_eq   = (AGE >= cfg.suffix_len) || (byte_q == suf_byte);
	end

endmodule

@@ design/swl_window.sv @@
// Byte window as a chain of cells plus the position count and the overflow flag.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module swl_window #(
	parameter int MAX_PATTERN = swl_pkg::MAX_PATTERN_DEF,
	parameter int MAX_TEXT    = swl_pkg::MAX_TEXT_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       en,
	input  logic [swl_pkg::BYTE_W-1:0] text_byte,
	input  logic                       last_in,
	input  swl_pkg::cfg_t              cfg,
	output swl_pkg::stage_t            stage
);
	import swl_pkg::*;

	localparam logic [POS_W-1:0] POS_LIMIT = POS_W'(MAX_TEXT);

	logic [BYTE_W-1:0]      chain [MAX_PATTERN];
	logic [MAX_PATTERN-1:0] pre_eq;
	logic [MAX_PATTERN-1:0] suf_eq;

	logic [POS_W-1:0] pos_q;
	logic             ovf_q;
	logic             clr_q;
	logic             pre_ok_s1;
	logic             suf_ok_s1;
	logic [POS_W-1:0] pre_start_s1;
	logic [POS_W-1:0] suf_start_s1;

	logic [POS_W-1:0] base_pos;
	logic             at_lim;
	logic             ovf_n;
	logic [POS_W-1:0] end_n;
	logic [POS_W-1:0] plen_w;
	logic [POS_W-1:0] slen_w;

	// clearing after the last byte is deferred to the next accepted byte,
	// so the tracker still sees the last window while it is busy with it
	for (genvar a = 0; a < MAX_PATTERN; a++) begin : g_cell
		if (a == 0) begin : g_head
			swl_cell #(.IDX(a)) u_cell (
				.clk     (clk),
				.arst_n  (arst_n),
				.en      (en),
				.clr     (1'b0),
				.byte_in (text_byte),
				.cfg     (cfg),
				.byte_q  (chain[a]),
				.pre_eq  (pre_eq[a]),
				.suf_eq  (suf_eq[a])
			);
		end else begin : g_body
			swl_cell #(.IDX(a)) u_cell (
				.clk     (clk),
				.arst_n  (arst_n),
				.en      (en),
				.clr     (clr_q),
				.byte_in (chain[a-1]),
				.cfg     (cfg),
				.byte_q  (chain[a]),
				.pre_eq  (pre_eq[a]),
				.suf_eq  (suf_eq[a])
			);
		end
	end

	always_comb begin
		base_pos = clr_q ? '0 : pos_q;
		at_lim   = base_pos >= POS_LIMIT;
		ovf_n    = (ovf_q && !clr_q) || at_lim;
		end_n    = at_lim ? POS_LIMIT : base_pos + POS_W'(1);
		plen_w   = POS_W'(cfg.prefix_len);
		slen_w   = POS_W'(cfg.suffix_len);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			ovf_q <= 1'b0;
			clr_q <= 1'b0;
		end else if (en) begin
			pos_q <= end_n;
			ovf_q <= ovf_n;
			clr_q <= last_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pre_ok_s1    <= ovf_n || (end_n >= plen_w);
			suf_ok_s1    <= ovf_n || (end_n >= slen_w);
			pre_start_s1 <= (end_n >= plen_w) ? end_n - plen_w : '0;
			suf_start_s1 <= (end_n >= slen_w) ? end_n - slen_w : '0;
		end
	end

	always_comb begin
		stage.pre_hit   = (&pre_eq) && pre_ok_s1;
		stage.suf_hit   = (&suf_eq) && suf_ok_s1;
		stage.end_pos   = pos_q;
		stage.pre_start = pre_start_s1;
		stage.suf_start = suf_start_s1;
		stage.last      = clr_q;
		stage.ovf       = ovf_q;
	end

	`SWL_ASSERT_IMP(a_pos_in_range, 1'b1, pos_q <= POS_LIMIT)
	`SWL_ASSERT_IMP(a_ovf_saturates, ovf_q, pos_q == POS_LIMIT)
	`SWL_ASSERT_NXT(a_fresh_text, en && clr_q, pos_q == POS_W'(1) && !ovf_q)

endmodule

@@ design/swl_tracker.sv @@
// Prefix tracking and best-length update, with the result register.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module swl_tracker (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              en,
	input  swl_pkg::stage_t                   stage,
	input  swl_pkg::cfg_t                     cfg,
	output logic signed [swl_pkg::BEST_W-1:0] best_length_s2,
	output logic                              text_done_s2,
	output logic                              overflow_s2
);
	import swl_pkg::*;

	logic                     found_q;
	logic [POS_W-1:0]         start_q;
	logic signed [BEST_W-1:0] best_q;

	logic                     found_n;
	logic [POS_W-1:0]         start_n;
	logic [BEST_W-1:0]        pre_end;
	logic [POS_W-1:0]         span;
	logic signed [BEST_W-1:0] span_s;
	logic                     take;
	logic signed [BEST_W-1:0] best_n;

	// the earliest prefix wins; an empty prefix sits at the start of text
	always_comb begin
		found_n = found_q || (cfg.prefix_len == '0) || stage.pre_hit;
		if (found_q) begin
			start_n = start_q;
		end else if (cfg.prefix_len == '0) begin
			start_n = '0;
		end else if (stage.pre_hit) begin
			start_n = stage.pre_start;
		end else begin
			start_n = start_q;
		end
		pre_end = {1'b0, start_n} + BEST_W'(cfg.prefix_len);
		span    = stage.end_pos - start_n;
		span_s  = $signed({1'b0, span});
		take    = found_n && stage.suf_hit && ({1'b0, stage.suf_start} >= pre_end)
			&& (span_s > best_q);
		best_n  = take ? span_s : best_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q <= 1'b0;
			start_q <= '0;
			best_q  <= BEST_NONE;
		end else if (en) begin
			if (stage.last) begin
				found_q <= 1'b0;
				start_q <= '0;
				best_q  <= BEST_NONE;
			end else begin
				found_q <= found_n;
				start_q <= start_n;
				best_q  <= best_n;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			best_length_s2 <= best_n;
			text_done_s2   <= stage.last;
			overflow_s2    <= stage.ovf;
		end
	end

	`SWL_ASSERT_IMP(a_best_floor, 1'b1, best_q >= BEST_NONE)
	`SWL_ASSERT_IMP(a_best_needs_prefix, best_q != BEST_NONE, found_q)
	`SWL_ASSERT_NXT(a_text_clears, en && stage.last, best_q == BEST_NONE && !found_q)

endmodule

@@ design/single_wildcard_longest_match.sv @@
// Path: a taken byte is held in the window, then the tracker's result register holds its
// result; an output stall can keep the byte in the window in between.
// Throughput: one byte per cycle unless the output is held.
// Backpressure stalls both stages; an empty stage one takes input while a result waits.
// Reset (arst_n low, asynchronous): window zeroed, position and flags cleared, best -1,
// pattern registers zero. No clearing pass; the block takes bytes from the first cycle.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module single_wildcard_longest_match #(
	parameter int MAX_PATTERN = swl_pkg::MAX_PATTERN_DEF,
	parameter int MAX_TEXT    = swl_pkg::MAX_TEXT_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	swl_in_if.sink      text_in,
	swl_out_if.source   result,
	swl_cfg_if.sink     cfg
);
	import swl_pkg::*;

	localparam logic [LEN_W-1:0] LEN_CAP = LEN_W'(MAX_PATTERN);

	// pattern registers, as written
	logic [CHARS_W-1:0] prefix_chars_q;
	logic [LEN_W-1:0]   prefix_len_q;
	logic [CHARS_W-1:0] suffix_chars_q;
	logic [LEN_W-1:0]   suffix_len_q;

	cfg_t   pat;
	stage_t stage;

	// handshake
	logic s1_valid_q;
	logic out_valid_q;
	logic advance;
	logic in_acc;
	logic trk_en;

	logic signed [BEST_W-1:0] best_length_s2;
	logic                     text_done_s2;
	logic                     overflow_s2;

	// ---------------------------------------------------------------
	// Configuration: always ready, lengths keep their low four bits.
	// Writes to indexes past the list are dropped.
	// ---------------------------------------------------------------
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prefix_chars_q <= '0;
			prefix_len_q   <= '0;
			suffix_chars_q <= '0;
			suffix_len_q   <= '0;
		end else if (cfg.valid && cfg.ready) begin
			case (cfg.index)
				REG_PREFIX_CHARS:  prefix_chars_q <= cfg.data;
				REG_PREFIX_LENGTH: prefix_len_q   <= cfg.data[LEN_W-1:0];
				REG_SUFFIX_CHARS:  suffix_chars_q <= cfg.data;
				REG_SUFFIX_LENGTH: suffix_len_q   <= cfg.data[LEN_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// lengths above the window depth act as the full depth
	always_comb begin
		pat.prefix_chars = prefix_chars_q;
		pat.prefix_len   = (prefix_len_q > LEN_CAP) ? LEN_CAP : prefix_len_q;
		pat.suffix_chars = suffix_chars_q;
		pat.suffix_len   = (suffix_len_q > LEN_CAP) ? LEN_CAP : suffix_len_q;
	end

	// ---------------------------------------------------------------
	// Two-stage pipe. Stage one is the window itself: its cells hold the
	// item's bytes while the tracker works on them, so it only moves on
	// when the tracker takes the item. The result register parts the
	// tracker from the output side.
	// ---------------------------------------------------------------
	assign advance       = !out_valid_q || result.ready;
	assign text_in.ready = !s1_valid_q || advance;
	assign in_acc        = text_in.valid && text_in.ready;
	assign trk_en        = s1_valid_q && advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_acc) begin
				s1_valid_q <= 1'b1;
			end else if (advance) begin
				s1_valid_q <= 1'b0;
			end
			if (trk_en) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	swl_window #(
		.MAX_PATTERN (MAX_PATTERN),
		.MAX_TEXT    (MAX_TEXT)
	) u_window (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (in_acc),
		.text_byte (text_in.text_byte),
		.last_in   (text_in.end_of_text),
		.cfg       (pat),
		.stage     (stage)
	);

	swl_tracker u_tracker (
		.clk            (clk),
		.arst_n         (arst_n),
		.en             (trk_en),
		.stage          (stage),
		.cfg            (pat),
		.best_length_s2 (best_length_s2),
		.text_done_s2   (text_done_s2),
		.overflow_s2    (overflow_s2)
	);

	assign result.valid       = out_valid_q;
	assign result.best_length = best_length_s2;
	assign result.text_done   = text_done_s2;
	assign result.overflow    = overflow_s2;

	// input stalls only with both stages full and the output held
	`SWL_ASSERT_IMP(a_stall_cause, !text_in.ready, s1_valid_q && out_valid_q && !result.ready)
	`SWL_ASSERT_NXT(a_item_lands, in_acc, s1_valid_q)
	`SWL_ASSERT_NXT(a_result_lands, trk_en, out_valid_q)

endmodule
